[rtl/core/pfs_pkg.sv]
// ----------------------------------------------------------------------------
// pfs_pkg
// Types, widths and codes shared by the palette fade sequencer.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int COLOR_W     = 12;
  localparam int NIB_W       = 4;
  localparam int STEPS_W     = 6;
  localparam int PEN_W       = 3;
  localparam int CH_N        = 3;
  localparam int NUM_W       = 10;
  localparam int QUO_W       = 5;
  localparam int CNT_W       = $clog2(QUO_W);

  localparam logic [NIB_W-1:0] NIB_MAX = 4'hF;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  typedef logic [NUM_W-1:0]  num_t;
  typedef num_t [CH_N-1:0]   num_vec_t;
  typedef logic [QUO_W-1:0]  quo_t;
  typedef quo_t [CH_N-1:0]   quo_vec_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [SLOT_W-1:0]  entry_index;
    logic [COLOR_W-1:0] entry_color;
    logic [STEPS_W-1:0] entry_steps;
    logic               entry_is_final;
    logic [PEN_W-1:0]   pen;
    logic [COLOR_W-1:0] resting_color;
  } pfs_in_t;

  typedef struct packed {
    logic [PEN_W-1:0] pen_out;
    logic [NIB_W-1:0] red;
    logic [NIB_W-1:0] green;
    logic [NIB_W-1:0] blue;
    logic [NIB_W-1:0] dark_red;
    logic [NIB_W-1:0] dark_green;
    logic [NIB_W-1:0] dark_blue;
    logic             finished;
  } pfs_out_t;

endpackage

[rtl/core/pfs_in_if.sv]
// ----------------------------------------------------------------------------
// pfs_in_if
// Request channel into the palette fade sequencer: valid, ready, payload.
// ----------------------------------------------------------------------------
interface pfs_in_if import pfs_pkg::*; ();
  logic    valid;
  logic    ready;
  pfs_in_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[rtl/core/pfs_out_if.sv]
// ----------------------------------------------------------------------------
// pfs_out_if
// Result channel out of the palette fade sequencer: valid, ready, payload.
// ----------------------------------------------------------------------------
interface pfs_out_if import pfs_pkg::*; ();
  logic     valid;
  logic     ready;
  pfs_out_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[rtl/core/pfs_div.sv]
// ----------------------------------------------------------------------------
// pfs_div
// Three-channel restoring divider sharing one divisor, one quotient bit
// per cycle; done is high for a single cycle, registered with the last bit.
// ----------------------------------------------------------------------------
module pfs_div import pfs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  num_vec_t           num,
  input  logic [STEPS_W-1:0] den,
  output quo_vec_t           quo,
  output logic               done
);

  num_vec_t           rem;
  num_vec_t           rem_next;
  logic [CH_N-1:0]    qbit;
  logic [STEPS_W-1:0] den_q;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [NUM_W:0]     shifted;

  always_comb begin
    shifted = {{(NUM_W + 1 - STEPS_W){1'b0}}, den_q} << cnt;
    for (int c = 0; c < CH_N; c++) begin
      if ({1'b0, rem[c]} >= shifted) begin
        rem_next[c] = rem[c] - shifted[NUM_W-1:0];
        qbit[c]     = 1'b1;
      end else begin
        rem_next[c] = rem[c];
        qbit[c]     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == '0);
      if (start) begin
        rem   <= num;
        den_q <= den;
        cnt   <= CNT_W'(QUO_W - 1);
        busy  <= 1'b1;
      end else if (busy) begin
        for (int c = 0; c < CH_N; c++) begin
          rem[c] <= rem_next[c];
          quo[c] <= {quo[c][QUO_W-2:0], qbit[c]};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/palette_fade_sequencer.sv]
// ----------------------------------------------------------------------------
// palette_fade_sequencer
// Plays a keyframe table on one palette pen, one interpolated color per
// frame tick, with a one-darker companion shade.
// ----------------------------------------------------------------------------
//  channel  role    payload
//  cmd      sink    func, entry_index/color/steps/is_final, pen, resting_color
//  res      source  pen_out, red/green/blue, dark_red/green/blue, finished
//
//  Load and start requests are done when accepted and give no result; a tick
//  opening a new span passes FETCH, MUL, DIV and PUT, one inside a span MUL,
//  DIV and PUT, a closing tick PUT only. The five-step restoring divider runs in DIV.
//  One request is in work at a time; cmd.ready is held low until its result
//  sits in the output register. rst is synchronous; the table is not cleared.
// ----------------------------------------------------------------------------
module palette_fade_sequencer import pfs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  pfs_in_if.sink   cmd,
  pfs_out_if.source res
);

  typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_MUL, ST_DIV, ST_PUT} state_t;

  typedef struct packed {
    logic               final_key;
    logic [STEPS_W-1:0] steps;
    logic [COLOR_W-1:0] color;
  } key_t;

  localparam logic [QUO_W-1:0] DITHER [CH_N] = '{5'd1, 5'd0, 5'd2};

  key_t key_mem [TABLE_DEPTH];
  key_t rd_q;

  state_t             state;
  logic               running;
  logic               fresh_start;
  logic [SLOT_W-1:0]  slot_pos;
  logic [STEPS_W-1:0] tick_in_span;
  logic [STEPS_W-1:0] span_len;
  logic [COLOR_W-1:0] from_color;
  logic [COLOR_W-1:0] to_color;
  logic               closing;
  logic [COLOR_W-1:0] home_color;
  logic [PEN_W-1:0]   active_pen;
  logic               fin;
  logic               out_valid;
  pfs_out_t           out_data;
  num_vec_t           num;
  logic               div_start;
  logic               div_done;
  quo_vec_t           quo;

  logic               cmd_acc;
  logic [SLOT_W-1:0]  f_slot;
  logic [STEPS_W-1:0] f_tick;
  logic [STEPS_W-1:0] f_span;
  logic [COLOR_W-1:0] f_to;
  logic               f_closing;
  logic [STEPS_W:0]   tick_inc;
  logic               span_over;
  logic               rd_en;
  logic [STEPS_W-1:0] left_ticks;
  logic [NIB_W-1:0]   sat [CH_N];

  assign cmd.ready = (state == ST_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign res.valid = out_valid;
  assign res.data  = out_data;

  always_comb begin
    f_slot    = fresh_start ? '0 : slot_pos;
    f_tick    = fresh_start ? '0 : tick_in_span;
    f_span    = fresh_start ? '0 : span_len;
    f_to      = fresh_start ? home_color : to_color;
    f_closing = fresh_start ? 1'b0 : closing;
    tick_inc  = {1'b0, f_tick} + 1'b1;
    span_over = tick_inc > {1'b0, f_span};
    rd_en     = cmd_acc && (cmd.data.func == FUNC_TICK) && running && span_over &&
                !f_closing;
    left_ticks = span_len - tick_in_span;
    for (int c = 0; c < CH_N; c++) begin
      sat[c] = (quo[c] > quo_t'(NIB_MAX)) ? NIB_MAX : quo[c][NIB_W-1:0];
    end
  end

  // table memory: write on load, registered read for the tick
  always_ff @(posedge clk) begin
    if (cmd_acc && (cmd.data.func == FUNC_LOAD)) begin
      key_mem[cmd.data.entry_index] <= '{
        final_key: cmd.data.entry_is_final,
        steps:     (cmd.data.entry_steps == '0) ? STEPS_W'(1) : cmd.data.entry_steps,
        color:     cmd.data.entry_color
      };
    end
    if (rd_en) begin
      rd_q <= key_mem[f_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      running      <= 1'b0;
      fresh_start  <= 1'b1;
      slot_pos     <= '0;
      tick_in_span <= '0;
      span_len     <= '0;
      from_color   <= '0;
      to_color     <= '0;
      closing      <= 1'b0;
      home_color   <= '0;
      active_pen   <= '0;
      fin          <= 1'b0;
      out_valid    <= 1'b0;
      div_start    <= 1'b0;
    end else begin
      div_start <= (state == ST_MUL);
      if (out_valid && res.ready && (state != ST_PUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_acc && (cmd.data.func == FUNC_START)) begin
            active_pen  <= cmd.data.pen;
            home_color  <= cmd.data.resting_color;
            running     <= 1'b1;
            fresh_start <= 1'b1;
            closing     <= 1'b0;
          end else if (cmd_acc && (cmd.data.func == FUNC_TICK) && running) begin
            slot_pos    <= f_slot;
            span_len    <= f_span;
            to_color    <= f_to;
            if (span_over) begin
              from_color   <= f_to;
              tick_in_span <= STEPS_W'(1);
              if (f_closing) begin
                running     <= 1'b0;
                closing     <= 1'b0;
                fresh_start <= 1'b1;
                fin         <= 1'b1;
                state       <= ST_PUT;
              end else begin
                fresh_start <= 1'b0;
                closing     <= f_closing;
                fin         <= 1'b0;
                state       <= ST_FETCH;
              end
            end else begin
              fresh_start  <= 1'b0;
              closing      <= f_closing;
              fin          <= 1'b0;
              tick_in_span <= tick_inc[STEPS_W-1:0];
              state        <= ST_MUL;
            end
          end
        end
        ST_FETCH: begin
          span_len <= (rd_q.steps == '0) ? STEPS_W'(1) : rd_q.steps;
          to_color <= rd_q.final_key ? home_color : rd_q.color;
          closing  <= rd_q.final_key;
          slot_pos <= slot_pos + 1'b1;
          state    <= ST_MUL;
        end
        ST_MUL: begin
          for (int c = 0; c < CH_N; c++) begin
            num[c] <= NUM_W'(to_color[COLOR_W-1-NIB_W*c -: NIB_W] * tick_in_span) +
                      NUM_W'(from_color[COLOR_W-1-NIB_W*c -: NIB_W] * left_ticks) +
                      NUM_W'(DITHER[c]);
          end
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (!out_valid || res.ready) begin
            out_valid        <= 1'b1;
            out_data.pen_out <= active_pen;
            out_data.finished <= fin;
            if (fin) begin
              out_data.red        <= '0;
              out_data.green      <= '0;
              out_data.blue       <= '0;
              out_data.dark_red   <= '0;
              out_data.dark_green <= '0;
              out_data.dark_blue  <= '0;
            end else begin
              out_data.red        <= sat[0];
              out_data.green      <= sat[1];
              out_data.blue       <= sat[2];
              out_data.dark_red   <= sat[0] - 1'b1;
              out_data.dark_green <= sat[1] - 1'b1;
              out_data.dark_blue  <= sat[2] - 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  pfs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (span_len),
    .quo   (quo),
    .done  (div_done)
  );

  a_mul_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (span_len != '0) && (tick_in_span != '0) &&
                          (tick_in_span <= span_len))
    else $error("tick position outside span at interpolation");

  a_done_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside divide state");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && (cmd.data.func == FUNC_LOAD)) |=> (state == ST_IDLE))
    else $error("load request left the idle state");

  a_fin_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.finished) |->
      (out_data.red == '0) && (out_data.green == '0) && (out_data.blue == '0))
    else $error("finished result carries a color");

endmodule
